// ===== rtl/hmd5_pkg.sv =====
// Shared types, constants and MD5 round tables for the HMAC-MD5 engine.
package hmd5_pkg;

	// Item codes on the request channel.
	typedef enum logic [1:0] {
		OP_KEY     = 2'd0,
		OP_MSG     = 2'd1,
		OP_END_MSG = 2'd2,
		OP_END_KEY = 2'd3
	} op_t;

	// Where the sixteen message words of one compression come from.
	typedef enum logic [2:0] {
		MD_FULL,
		MD_PAD_MARK,
		MD_PAD_LEN,
		MD_LEN_ONLY,
		MD_OUTER,
		MD_IPAD,
		MD_OPAD
	} mode_t;

	// Starting chain of one compression.
	typedef enum logic [1:0] {
		SRC_IV,
		SRC_CHAIN,
		SRC_OUTER
	} src_t;

	// Register that takes the result of one compression.
	typedef enum logic [1:0] {
		DST_CHAIN,
		DST_INNER,
		DST_OUTER,
		DST_DIG
	} dst_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  key_start;
		logic  key_wr;
		logic  absorb;
		logic  start;
		mode_t mode;
		src_t  src;
		dst_t  dst;
		logic  set_key;
		logic  key_use;
		logic  key_long;
		logic  reinit;
		logic  cap_out;
		logic  out_half;
	} hmd5_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;
		logic done;
		logic last_slot;
		logic idx_hi;
		logic key_long;
	} hmd5_sts_t;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IPAD_WORD = 32'h36363636;
	localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [31:0] PAD_MARK_WORD = 32'h00000080;
	// Outer message is 64 key bytes plus the 16-byte inner digest.
	localparam logic [31:0] OUTER_LEN_BITS = 32'd640;

	// Additive constant of each round.
	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	// Rotate amount of each round.
	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	// Message word used by each round.
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] lo;
		logic [3:0] g;
		lo = i[3:0];
		case (i[5:4])
			2'd0: g = lo;
			2'd1: g = lo * 4'd5 + 4'd1;
			2'd2: g = lo * 4'd3 + 4'd5;
			default: g = lo * 4'd7;
		endcase
		return g;
	endfunction

	// Reverses the byte order of a word.
	function automatic logic [31:0] bswap32(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

// ===== rtl/hmd5_in_if.sv =====
// Request channel carrying one key or message item.
interface hmd5_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_byte;

	modport source(output valid, output op, output data_byte, input ready);
	modport sink(input valid, input op, input data_byte, output ready);
endinterface

// ===== rtl/hmd5_out_if.sv =====
// Result channel carrying one half of the HMAC digest.
interface hmd5_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_half;
	logic        half_index;
	logic        last_half;

	modport source(output valid, output digest_half, output half_index, output last_half,
		input ready);
	modport sink(input valid, input digest_half, input half_index, input last_half,
		output ready);
endinterface

// ===== rtl/hmd5_datapath.sv =====
// MD5 datapath: block and key buffers, chaining registers and the shared round unit.
module hmd5_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  hmd5_pkg::hmd5_cmd_t cmd,
	input  logic [7:0]         data_byte,
	output hmd5_pkg::hmd5_sts_t sts,
	output logic [63:0]        digest_half
);
	import hmd5_pkg::*;

	logic [31:0] blk_mem [16];
	logic [31:0] key_mem [16];
	logic [31:0] blk_rd_q;
	logic [31:0] key_rd_q;
	logic [3:0]  rd_addr;
	logic [3:0]  g_q;

	logic [63:0] byte_count_q;
	logic [63:0] key_length_q;
	logic [63:0] bc_eff;
	logic [63:0] kl_eff;
	logic [6:0]  kl_q;
	logic        klong_q;

	logic [3:0][31:0] chain_q;
	logic [3:0][31:0] inner_q;
	logic [3:0][31:0] outer_q;
	logic [3:0][31:0] dig_q;
	logic [3:0][31:0] base_q;
	logic [3:0][31:0] src_val;
	logic [3:0][31:0] res;

	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        done_q;
	mode_t       mode_q;
	dst_t        dst_q;
	logic [63:0] out_hi_q;
	logic [63:0] out_lo_q;

	logic [5:0]  pos;
	logic [63:0] len_bits;
	logic [31:0] pad_w;
	logic [31:0] key_w;
	logic [31:0] m_word;
	logic [31:0] f;
	logic [31:0] sum;
	logic [31:0] rot;
	logic [4:0]  sh;
	logic [31:0] nb;

	// A new key load restarts both counters in the same cycle as its first byte.
	assign bc_eff = cmd.key_start ? '0 : byte_count_q;
	assign kl_eff = cmd.key_start ? '0 : key_length_q;

	// Prefetch the message word of the next round.
	assign rd_addr = busy_q ? md5_g(rnd_q + 6'd1) : 4'd0;

	// Byte writes into the two buffers, registered word reads.
	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			blk_mem[bc_eff[5:2]][{bc_eff[1:0], 3'b000} +: 8] <= data_byte;
		end
		if (cmd.key_wr && (kl_eff < 64'd64)) begin
			key_mem[kl_eff[5:2]][{kl_eff[1:0], 3'b000} +: 8] <= data_byte;
		end
		blk_rd_q <= blk_mem[rd_addr];
		key_rd_q <= key_mem[rd_addr];
	end

	// Starting chain selection.
	always_comb begin
		case (cmd.src)
			SRC_IV:    src_val = {IV3, IV2, IV1, IV0};
			SRC_CHAIN: src_val = chain_q;
			SRC_OUTER: src_val = outer_q;
			default:   src_val = chain_q;
		endcase
	end

	// Message word generation, including MD5 padding and the HMAC key pads.
	always_comb begin
		len_bits = {byte_count_q[60:0], 3'b000};
		pad_w = '0;
		key_w = '0;
		pos = '0;
		for (int k = 0; k < 4; k++) begin
			pos = {g_q, 2'(k)};
			if ((mode_q inside {MD_PAD_MARK, MD_PAD_LEN}) && (pos < byte_count_q[5:0])) begin
				pad_w[8*k +: 8] = blk_rd_q[8*k +: 8];
			end else if ((mode_q inside {MD_PAD_MARK, MD_PAD_LEN}) &&
				(pos == byte_count_q[5:0])) begin
				pad_w[8*k +: 8] = PAD_MARK;
			end
			if ({1'b0, pos} < kl_q) begin
				key_w[8*k +: 8] = key_rd_q[8*k +: 8];
			end
		end
		if ((mode_q inside {MD_PAD_LEN, MD_LEN_ONLY}) && (g_q == 4'd14)) begin
			pad_w = len_bits[31:0];
		end else if ((mode_q inside {MD_PAD_LEN, MD_LEN_ONLY}) && (g_q == 4'd15)) begin
			pad_w = len_bits[63:32];
		end
		if (klong_q) begin
			key_w = (g_q < 4'd4) ? dig_q[g_q[1:0]] : '0;
		end
		case (mode_q)
			MD_FULL: m_word = blk_rd_q;
			MD_PAD_MARK, MD_PAD_LEN, MD_LEN_ONLY: m_word = pad_w;
			MD_OUTER: begin
				if (g_q < 4'd4) begin
					m_word = dig_q[g_q[1:0]];
				end else if (g_q == 4'd4) begin
					m_word = PAD_MARK_WORD;
				end else if (g_q == 4'd14) begin
					m_word = OUTER_LEN_BITS;
				end else begin
					m_word = '0;
				end
			end
			MD_IPAD: m_word = key_w ^ IPAD_WORD;
			MD_OPAD: m_word = key_w ^ OPAD_WORD;
			default: m_word = blk_rd_q;
		endcase
	end

	// One MD5 round.
	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum = f + a_q + md5_k(rnd_q) + m_word;
		sh = md5_s(rnd_q);
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
		nb = b_q + rot;
		res[0] = base_q[0] + d_q;
		res[1] = base_q[1] + nb;
		res[2] = base_q[2] + b_q;
		res[3] = base_q[3] + c_q;
	end

	// Counters, chaining registers and the round sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			key_length_q <= '0;
			kl_q <= '0;
			klong_q <= 1'b0;
			chain_q <= {IV3, IV2, IV1, IV0};
			inner_q <= '0;
			outer_q <= '0;
			dig_q <= '0;
			base_q <= '0;
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			rnd_q <= '0;
			g_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= MD_FULL;
			dst_q <= DST_CHAIN;
			out_hi_q <= '0;
			out_lo_q <= '0;
		end else begin
			done_q <= 1'b0;
			g_q <= rd_addr;
			if (cmd.key_start) begin
				chain_q <= {IV3, IV2, IV1, IV0};
				key_length_q <= '0;
				byte_count_q <= '0;
			end
			if (cmd.key_wr) begin
				key_length_q <= kl_eff + 64'd1;
			end
			if (cmd.absorb) begin
				byte_count_q <= bc_eff + 64'd1;
			end
			if (cmd.reinit) begin
				chain_q <= inner_q;
				byte_count_q <= 64'd64;
			end
			if (cmd.set_key) begin
				klong_q <= cmd.key_long;
				kl_q <= cmd.key_use ? key_length_q[6:0] : 7'd0;
			end
			if (cmd.cap_out) begin
				out_hi_q <= {bswap32(dig_q[0]), bswap32(dig_q[1])};
				out_lo_q <= {bswap32(dig_q[2]), bswap32(dig_q[3])};
			end
			if (cmd.start) begin
				{d_q, c_q, b_q, a_q} <= src_val;
				base_q <= src_val;
				rnd_q <= '0;
				busy_q <= 1'b1;
				mode_q <= cmd.mode;
				dst_q <= cmd.dst;
			end else if (busy_q) begin
				a_q <= d_q;
				d_q <= c_q;
				c_q <= b_q;
				b_q <= nb;
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					case (dst_q)
						DST_CHAIN: chain_q <= res;
						DST_INNER: inner_q <= res;
						DST_OUTER: outer_q <= res;
						DST_DIG:   dig_q <= res;
						default:   chain_q <= res;
					endcase
				end
			end
		end
	end

	// Status towards the controller.
	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.last_slot = (byte_count_q[5:0] == 6'd63);
	assign sts.idx_hi = (byte_count_q[5:0] >= 6'd56);
	assign sts.key_long = (key_length_q > 64'd64);

	assign digest_half = cmd.out_half ? out_lo_q : out_hi_q;

endmodule

// ===== rtl/hmd5_ctrl.sv =====
// Controller: request decoding, key and message phase, compression sequencing, result hand-off.
module hmd5_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_half,
	output hmd5_pkg::hmd5_cmd_t cmd,
	input  hmd5_pkg::hmd5_sts_t sts
);
	import hmd5_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BLK,
		ST_FIN1,
		ST_FIN2,
		ST_OUTER,
		ST_IPAD,
		ST_OPAD
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_KEY,
		PH_READY
	} phase_t;

	state_t st_q;
	state_t st_d;
	phase_t phase_q;
	logic   ctx_key_q;
	logic   out_pend_q;
	logic   half_q;
	logic   in_acc;
	logic   out_acc;
	op_t    op;

	assign op = op_t'(in_op);
	// A new end of message waits until the previous digest has gone out.
	assign in_ready = (st_q == ST_IDLE) && !(out_pend_q && (op == OP_END_MSG));
	assign in_acc = in_valid && in_ready;
	assign out_valid = out_pend_q;
	assign out_half = half_q;
	assign out_acc = out_pend_q && out_ready;

	// Command decoding and next state.
	always_comb begin
		cmd = '0;
		cmd.mode = MD_FULL;
		cmd.src = SRC_CHAIN;
		cmd.dst = DST_CHAIN;
		cmd.out_half = half_q;
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (op)
						OP_KEY: begin
							cmd.key_start = (phase_q != PH_KEY);
							cmd.key_wr = 1'b1;
							cmd.absorb = 1'b1;
							if ((phase_q == PH_KEY) && sts.last_slot) begin
								cmd.start = 1'b1;
								st_d = ST_BLK;
							end
						end
						OP_MSG: begin
							if (phase_q != PH_KEY) begin
								cmd.absorb = 1'b1;
								if (sts.last_slot) begin
									cmd.start = 1'b1;
									st_d = ST_BLK;
								end
							end
						end
						OP_END_MSG: begin
							if (phase_q != PH_KEY) begin
								cmd.start = 1'b1;
								cmd.mode = sts.idx_hi ? MD_PAD_MARK : MD_PAD_LEN;
								cmd.dst = sts.idx_hi ? DST_CHAIN : DST_DIG;
								st_d = sts.idx_hi ? ST_FIN1 : ST_FIN2;
							end
						end
						default: begin
							if ((phase_q == PH_KEY) && sts.key_long) begin
								cmd.start = 1'b1;
								cmd.mode = sts.idx_hi ? MD_PAD_MARK : MD_PAD_LEN;
								cmd.dst = sts.idx_hi ? DST_CHAIN : DST_DIG;
								st_d = sts.idx_hi ? ST_FIN1 : ST_FIN2;
							end else begin
								cmd.set_key = 1'b1;
								cmd.key_use = (phase_q == PH_KEY);
								cmd.start = 1'b1;
								cmd.mode = MD_IPAD;
								cmd.src = SRC_IV;
								cmd.dst = DST_INNER;
								st_d = ST_IPAD;
							end
						end
					endcase
				end
			end
			ST_BLK: begin
				if (sts.done) begin
					st_d = ST_IDLE;
				end
			end
			ST_FIN1: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.mode = MD_LEN_ONLY;
					cmd.dst = DST_DIG;
					st_d = ST_FIN2;
				end
			end
			ST_FIN2: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					if (ctx_key_q) begin
						cmd.set_key = 1'b1;
						cmd.key_use = 1'b1;
						cmd.key_long = 1'b1;
						cmd.mode = MD_IPAD;
						cmd.src = SRC_IV;
						cmd.dst = DST_INNER;
						st_d = ST_IPAD;
					end else begin
						cmd.mode = MD_OUTER;
						cmd.src = SRC_OUTER;
						cmd.dst = DST_DIG;
						st_d = ST_OUTER;
					end
				end
			end
			ST_OUTER: begin
				if (sts.done) begin
					cmd.cap_out = 1'b1;
					cmd.reinit = 1'b1;
					st_d = ST_IDLE;
				end
			end
			ST_IPAD: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.mode = MD_OPAD;
					cmd.src = SRC_IV;
					cmd.dst = DST_OUTER;
					st_d = ST_OPAD;
				end
			end
			ST_OPAD: begin
				if (sts.done) begin
					cmd.reinit = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// State, phase and result hand-off registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			phase_q <= PH_IDLE;
			ctx_key_q <= 1'b0;
			out_pend_q <= 1'b0;
			half_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (in_acc && (op == OP_KEY)) begin
				phase_q <= PH_KEY;
			end
			if (in_acc && (op == OP_END_KEY)) begin
				ctx_key_q <= 1'b1;
			end else if (in_acc && (op == OP_END_MSG)) begin
				ctx_key_q <= 1'b0;
			end
			if ((st_q == ST_OPAD) && sts.done) begin
				phase_q <= PH_READY;
			end
			if (out_acc) begin
				if (half_q) begin
					out_pend_q <= 1'b0;
					half_q <= 1'b0;
				end else begin
					half_q <= 1'b1;
				end
			end
			if ((st_q == ST_OUTER) && sts.done) begin
				out_pend_q <= 1'b1;
				half_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/hmac_md5_engine_core.sv =====
// HMAC-MD5 engine top level: controller, datapath and the two channels.
//
// Streaming HMAC-MD5 over one byte per request. Key and message bytes are accepted
// whenever the engine is idle; every 64th absorbed byte starts an MD5 compression in
// the shared round unit, which does one round per cycle, so the block stops taking
// requests after that byte until the compression has finished. An end of message runs
// one or two inner padding blocks and the outer block, and then offers the digest
// as two results, first eight digest bytes first; a further end of message is held off
// until both have been taken, while key and message bytes are still accepted. An end of
// key runs the inner and outer key pads (two compressions), plus one or two more to
// reduce a key longer than 64 bytes to its digest. A message sent before any key gives
// a result without meaning.
module hmac_md5_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	hmd5_in_if.sink    in_ch,
	hmd5_out_if.source out_ch
);
	import hmd5_pkg::*;

	hmd5_cmd_t dp_cmd;
	hmd5_sts_t dp_sts;
	logic      out_half;

	// Sequencer.
	hmd5_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_half  (out_half),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

	// Buffers, chains and round unit.
	hmd5_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.data_byte   (in_ch.data_byte),
		.sts         (dp_sts),
		.digest_half (out_ch.digest_half)
	);

	assign out_ch.half_index = out_half;
	assign out_ch.last_half = out_half;

	// No request is taken while a compression runs.
	a_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		dp_sts.busy |-> !in_ch.ready)
		else $error("request accepted during compression");

	// The cycle after a compression ends the controller is still sequencing.
	a_done_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		dp_sts.done |-> !in_ch.ready)
		else $error("request accepted on compression completion");

	// The first half is always followed by the second.
	a_second_half: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.last_half) |=>
		(out_ch.valid && out_ch.last_half))
		else $error("second digest half missing");

	// A digest always starts with its first half.
	a_first_half: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> !out_ch.half_index)
		else $error("digest started with the second half");

endmodule

// ===== tb/hmac_md5_engine_core_tb.sv =====
// Self-checking testbench for the streaming HMAC-MD5 engine with its own digest predictor.
`timescale 1ns / 100ps

module hmac_md5_engine_core_tb;
	import hmd5_pkg::*;

	localparam int CLK_PERIOD  = 12;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 300;

	typedef logic [31:0] chain_t [4];
	typedef logic [7:0]  block_t [64];
	typedef logic [7:0]  digest_t [16];

	typedef enum logic [1:0] {KS_NONE, KS_LOADING, KS_READY} key_state_t;

	// One half of a predicted digest.
	typedef struct {
		logic [63:0] digest_half;
		logic        half_index;
		logic        last_half;
	} half_t;

	logic clk;
	logic arst_n;

	hmd5_in_if  in_ch ();
	hmd5_out_if out_ch ();

	hmac_md5_engine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// MD5 round constants and rotate amounts.
	localparam logic [31:0] RND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int RND_ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
	localparam chain_t MD5_START = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

	// Predictor state.
	block_t      key_bytes;
	logic [63:0] key_count;
	chain_t      inner_mid;
	chain_t      outer_mid;
	chain_t      run_chain;
	block_t      part_block;
	logic [63:0] hashed_count;
	key_state_t  key_state;

	half_t digest_q[$];

	int mismatches;
	int halves_checked;
	int reqs_sent;
	int keys_loaded;
	int msgs_ended;
	int burst_left;
	int cycles;

	// One MD5 compression of a 64-byte block into the chain.
	function automatic void md5_block(inout chain_t h, input block_t blk);
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f;
		int g, r, s;
		for (int i = 0; i < 16; i++)
			m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		a = h[0]; b = h[1]; c = h[2]; d = h[3];
		for (int i = 0; i < 64; i++) begin
			r = i / 16;
			case (r)
				0: begin f = (b & c) | (~b & d); g = i; end
				1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
			endcase
			f = f + a + RND_K[i] + m[g];
			s = RND_ROT[r * 4 + i % 4];
			a = d; d = c; c = b;
			b = b + ((f << s) | (f >> (32 - s)));
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d;
	endfunction

	// Pads the partial block, runs the last compressions and returns the digest bytes.
	function automatic void md5_close(inout chain_t h, inout block_t blk,
		input logic [63:0] count, output digest_t dig);
		int idx;
		logic [63:0] bits;
		idx = int'(count[5:0]);
		bits = count << 3;
		blk[idx] = 8'h80;
		idx++;
		if (idx > 56) begin
			for (int i = idx; i < 64; i++) blk[i] = 8'h00;
			md5_block(h, blk);
			idx = 0;
		end
		for (int i = idx; i < 56; i++) blk[i] = 8'h00;
		for (int i = 0; i < 8; i++) blk[56+i] = bits[8*i +: 8];
		md5_block(h, blk);
		for (int i = 0; i < 16; i++) dig[i] = h[i/4][8*(i%4) +: 8];
	endfunction

	// Feeds one byte into the running hash.
	function automatic void hash_byte(input logic [7:0] v);
		part_block[hashed_count[5:0]] = v;
		hashed_count++;
		if (hashed_count[5:0] == 6'd0)
			md5_block(run_chain, part_block);
	endfunction

	// Builds the inner and outer midstates from the key collected so far.
	function automatic void derive_pads();
		block_t  key, pad;
		digest_t kd;
		int klen;
		for (int i = 0; i < 64; i++) key[i] = 8'h00;
		if (key_state == KS_LOADING && key_count > 64) begin
			md5_close(run_chain, part_block, hashed_count, kd);
			for (int i = 0; i < 16; i++) key[i] = kd[i];
		end else begin
			klen = (key_state == KS_LOADING) ? int'(key_count) : 0;
			for (int i = 0; i < klen; i++) key[i] = key_bytes[i];
		end
		for (int i = 0; i < 64; i++) pad[i] = key[i] ^ 8'h36;
		inner_mid = MD5_START;
		md5_block(inner_mid, pad);
		for (int i = 0; i < 64; i++) pad[i] = key[i] ^ 8'h5c;
		outer_mid = MD5_START;
		md5_block(outer_mid, pad);
		run_chain = inner_mid;
		hashed_count = 64;
		key_state = KS_READY;
	endfunction

	// Advances the predictor by one accepted request and queues any digest halves.
	function automatic void predict_hmac(input op_t op, input logic [7:0] v);
		digest_t idig, dig;
		block_t  blk;
		chain_t  h;
		half_t   e;
		case (op)
			OP_KEY: begin
				if (key_state != KS_LOADING) begin
					key_state = KS_LOADING;
					key_count = 0;
					hashed_count = 0;
					run_chain = MD5_START;
				end
				if (key_count < 64) key_bytes[key_count[5:0]] = v;
				key_count++;
				hash_byte(v);
			end
			OP_END_KEY: derive_pads();
			OP_MSG: if (key_state != KS_LOADING) hash_byte(v);
			default: if (key_state != KS_LOADING) begin
				md5_close(run_chain, part_block, hashed_count, idig);
				h = outer_mid;
				for (int i = 0; i < 64; i++) blk[i] = 8'h00;
				for (int i = 0; i < 16; i++) blk[i] = idig[i];
				md5_close(h, blk, 64'd80, dig);
				e.digest_half = {dig[0], dig[1], dig[2], dig[3], dig[4], dig[5], dig[6], dig[7]};
				e.half_index = 1'b0;
				e.last_half = 1'b0;
				digest_q.push_back(e);
				e.digest_half = {dig[8], dig[9], dig[10], dig[11],
					dig[12], dig[13], dig[14], dig[15]};
				e.half_index = 1'b1;
				e.last_half = 1'b1;
				digest_q.push_back(e);
				run_chain = inner_mid;
				hashed_count = 64;
			end
		endcase
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d halves outstanding",
				cycles, digest_q.size());
			$display("hmac_md5_engine_core_tb: FAIL");
			$finish;
		end
	end

	// Sends one request, waits for it to be taken, then idles between bursts.
	task automatic send_req(input op_t op, input logic [7:0] v);
		in_ch.valid     <= 1'b1;
		in_ch.op        <= op;
		in_ch.data_byte <= v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_hmac(op, v);
		reqs_sent++;
		if (op == OP_END_KEY) keys_loaded++;
		if (op == OP_END_MSG) msgs_ended++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic send_key(input int len);
		for (int i = 0; i < len; i++) send_req(OP_KEY, 8'($urandom));
		send_req(OP_END_KEY, 8'($urandom));
	endtask

	task automatic send_msg(input int len);
		for (int i = 0; i < len; i++) send_req(OP_MSG, 8'($urandom));
		send_req(OP_END_MSG, 8'($urandom));
	endtask

	// Result checker and receiver stall pattern.
	int rx_run;
	int rx_mode;
	logic rx_level;
	always @(posedge clk) begin
		half_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			halves_checked++;
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected digest half %h idx %0d last %0d",
						out_ch.digest_half, out_ch.half_index, out_ch.last_half);
			end else begin
				e = digest_q.pop_front();
				if (out_ch.digest_half !== e.digest_half || out_ch.half_index !== e.half_index
					|| out_ch.last_half !== e.last_half) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Digest half mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
							e.digest_half, e.half_index, e.last_half,
							out_ch.digest_half, out_ch.half_index, out_ch.last_half);
				end
			end
		end
		if (cycles % 256 == 0) rx_mode = $urandom_range(0, 2);
		if (rx_run == 0) begin
			rx_level = (rx_mode == 0) ? 1'b1 : 1'($urandom_range(0, 1));
			rx_run = (rx_mode == 2) ? $urandom_range(5, 60) : $urandom_range(1, 3);
		end
		rx_run--;
		out_ch.ready <= rx_level;
	end

	// A message before any key hashes from the initial values, then from zero midstates.
	task automatic test_message_before_key();
		send_msg(3);
		send_msg(0);
	endtask

	// Empty key from an end of key outside a load, then keys of one and 64 bytes.
	task automatic test_short_keys();
		send_req(OP_END_KEY, 8'hff);
		send_msg(1);
		send_req(OP_KEY, 8'h00);
		send_req(OP_END_KEY, 8'h00);
		send_req(OP_MSG, 8'hff);
		send_req(OP_MSG, 8'h00);
		send_req(OP_END_MSG, 8'h00);
		send_key(64);
		send_msg(0);
	endtask

	// A key one byte over the block is reduced to its digest first.
	task automatic test_long_key();
		send_key(65);
		send_msg(2);
	endtask

	// Message items inside a key load are dropped; a key byte abandons a partial message.
	task automatic test_ignored_and_restart();
		send_req(OP_KEY, 8'h5a);
		send_req(OP_MSG, 8'ha5);
		send_req(OP_END_MSG, 8'h00);
		send_req(OP_END_KEY, 8'h00);
		send_req(OP_MSG, 8'h11);
		send_req(OP_KEY, 8'h22);
		send_req(OP_END_KEY, 8'h00);
		send_msg(1);
	endtask

	// Mostly well-formed key loads and messages, with some stray items mixed in.
	task automatic test_random_traffic();
		int target;
		target = 800;
		while (reqs_sent < target) begin
			case ($urandom_range(0, 9))
				0: send_key($urandom_range(0, 3) == 0 ? $urandom_range(65, 140)
					: $urandom_range(0, 64));
				1: send_req(op_t'($urandom_range(0, 3)), 8'($urandom));
				default: send_msg($urandom_range(0, 7) == 0 ? $urandom_range(56, 130)
					: $urandom_range(0, 40));
			endcase
		end
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_KEY;
		in_ch.data_byte = 8'h00;
		out_ch.ready = 1'b0;
		cycles = 0;
		mismatches = 0;
		halves_checked = 0;
		reqs_sent = 0;
		keys_loaded = 0;
		msgs_ended = 0;
		burst_left = 0;
		rx_run = 0;
		rx_mode = 0;
		key_count = 0;
		inner_mid = '{default: 32'h0};
		outer_mid = '{default: 32'h0};
		run_chain = MD5_START;
		hashed_count = 0;
		key_state = KS_NONE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_message_before_key();
		test_short_keys();
		test_long_key();
		test_ignored_and_restart();
		test_random_traffic();

		in_ch.valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d requests: %0d key loads and %0d ends of message.",
			reqs_sent, keys_loaded, msgs_ended);
		$display("Checked %0d digest halves, %0d mismatching.", halves_checked, mismatches);
		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("hmac_md5_engine_core_tb: PASS");
		end else begin
			$display("hmac_md5_engine_core_tb: FAIL");
		end
		$finish;
	end

endmodule
